// ----- design/ttcpg_pkg.sv -----
package ttcpg_pkg;

    // Fixed field widths of the item and result channels
    localparam int ROW_BITS_W   = 36;
    localparam int PATTERN_W    = 64;
    localparam int CODE_W       = 8;
    localparam int INDEX_W      = 6;
    localparam int MAXCOL_W     = 16;
    localparam int SCOUNT_W     = 7;
    localparam int CFG_DATA_W   = 16;

    // Item opcodes
    localparam logic [1:0] OP_LOAD_ROW    = 2'd0;
    localparam logic [1:0] OP_LOAD_SYMBOL = 2'd1;
    localparam logic [1:0] OP_TEXT_CHAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_COLUMNS  = 1'b0;
    localparam logic CFG_SPRITE_COUNT = 1'b1;

    localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNKNOWN  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        K_ROW    = 2'd0,
        K_SYMBOL = 2'd1,
        K_CHAR   = 2'd2
    } kind_t;

    // Classified item, as it travels from front to back
    typedef struct packed {
        kind_t                 kind;
        logic [INDEX_W-1:0]    sprite_index;
        logic [INDEX_W-1:0]    row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [CODE_W-1:0]     char_code;
        logic                  first_char;
        logic                  last_char;
    } entry_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] column_pattern;
        status_t              status;
        logic                 last;
    } result_t;

endpackage

// ----- design/ttcpg_ram.sv -----
module ttcpg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                            rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- design/ttcpg_fifo.sv -----
module ttcpg_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    // Advance pointers and count, wrapping at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/ttcpg_front.sv -----
module ttcpg_front #(
    parameter int HEIGHT      = 64,
    parameter int MAX_SPRITES = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [1:0]                            opcode,
    input  logic [ttcpg_pkg::INDEX_W-1:0]         sprite_index,
    input  logic [ttcpg_pkg::INDEX_W-1:0]         row_index,
    input  logic [ttcpg_pkg::ROW_BITS_W-1:0]      row_bits,
    input  logic [ttcpg_pkg::CODE_W-1:0]          char_code,
    input  logic                                  first_char,
    input  logic                                  last_char,
    input  logic                                  q_pop,
    output logic                                  q_empty,
    output ttcpg_pkg::entry_t                     q_head
);

    ttcpg_pkg::entry_t entry;
    logic              keep;
    logic              sprite_ok;
    logic              row_ok;

    assign sprite_ok = (32'(sprite_index) < MAX_SPRITES);
    assign row_ok    = (32'(row_index) < HEIGHT);

    // Classify the item; drop out-of-range loads and unused opcodes
    always_comb
    begin
        entry.sprite_index = sprite_index;
        entry.row_index    = row_index;
        entry.row_bits     = row_bits;
        entry.char_code    = char_code;
        entry.first_char   = first_char;
        entry.last_char    = last_char;
        entry.kind         = ttcpg_pkg::K_CHAR;
        keep               = 1'b0;
        case (opcode)
            ttcpg_pkg::OP_LOAD_ROW:
            begin
                entry.kind = ttcpg_pkg::K_ROW;
                keep       = sprite_ok && row_ok;
            end
            ttcpg_pkg::OP_LOAD_SYMBOL:
            begin
                entry.kind = ttcpg_pkg::K_SYMBOL;
                keep       = sprite_ok;
            end
            ttcpg_pkg::OP_TEXT_CHAR:
            begin
                entry.kind = ttcpg_pkg::K_CHAR;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Queue classified items toward the back end
    ttcpg_fifo #(
        .DATA_W ($bits(ttcpg_pkg::entry_t)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (entry),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_head),
        .empty (q_empty)
    );

endmodule

// ----- design/ttcpg_back.sv -----
module ttcpg_back #(
    parameter int WIDTH       = 36,
    parameter int HEIGHT      = 64,
    parameter int MAX_SPRITES = 64,
    parameter int SPACING     = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ttcpg_pkg::MAXCOL_W-1:0]    max_columns,
    input  logic [ttcpg_pkg::SCOUNT_W-1:0]    sprite_count,
    input  logic                              q_empty,
    input  ttcpg_pkg::entry_t                 q_head,
    output logic                              q_pop,
    input  logic                              out_full,
    output logic                              out_push,
    output ttcpg_pkg::result_t                out_item
);

    localparam int SIDX_W    = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam int ROW_W     = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int LIM_W     = $clog2(MAX_SPRITES + 1);
    localparam int F_W       = $clog2(HEIGHT + 1);
    localparam int TOT_W     = $clog2(WIDTH + SPACING + 1);
    localparam int ROW_DEPTH = 2 ** (SIDX_W + ROW_W);
    localparam int SYM_DEPTH = 2 ** SIDX_W;
    localparam int RB_W      = ttcpg_pkg::ROW_BITS_W;
    localparam int MC_W      = ttcpg_pkg::MAXCOL_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_FETCH  = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [MC_W-1:0]              count_reg, count_next;
    logic                         aborted_reg, aborted_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic                         rv_reg, rv_next;
    logic [ttcpg_pkg::CODE_W-1:0] code_reg, code_next;
    logic                         is_char_reg, is_char_next;
    logic [LIM_W-1:0]             idx_reg, idx_next;
    logic [SIDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [SIDX_W-1:0]            sp_reg, sp_next;
    logic [F_W-1:0]               f_reg, f_next;
    logic [TOT_W-1:0]             col_reg, col_next;
    logic [TOT_W-1:0]             total_reg, total_next;
    logic [RB_W-1:0]              rowbuf_reg [HEIGHT];

    logic [LIM_W-1:0]                 lim;
    logic [MC_W-1:0]                  cnt_start;
    logic                             abort_start;
    logic                             shift_in;
    logic                             shift_out;
    logic                             col_last;
    logic [ttcpg_pkg::PATTERN_W-1:0]  column_word;

    logic                             row_we;
    logic [SIDX_W+ROW_W-1:0]          row_waddr, row_raddr;
    logic [RB_W-1:0]                  row_rdata;
    logic                             sym_we;
    logic [SIDX_W-1:0]                sym_waddr, sym_raddr;
    logic [ttcpg_pkg::CODE_W-1:0]     sym_rdata;

    // Saturate the searched sprite count at the font size
    assign lim = (9'(sprite_count) > 9'(MAX_SPRITES)) ? LIM_W'(MAX_SPRITES)
                                                       : LIM_W'(sprite_count);

    assign cnt_start   = q_head.first_char ? '0 : count_reg;
    assign abort_start = q_head.first_char ? 1'b0 : aborted_reg;

    assign row_waddr = {SIDX_W'(q_head.sprite_index), ROW_W'(q_head.row_index)};
    assign row_raddr = {sp_reg, f_reg[ROW_W-1:0]};
    assign sym_waddr = SIDX_W'(q_head.sprite_index);
    assign sym_raddr = idx_reg[SIDX_W-1:0];
    assign col_last  = (col_reg == TOT_W'(total_reg - 1'b1));

    // Take bit 0 of every buffered row as the current column
    always_comb
    begin
        column_word = '0;
        for (int r = 0; r < HEIGHT; r++)
        begin
            column_word[r] = rowbuf_reg[r][0];
        end
    end

    // Sequence load writes, symbol search, row fetch and column output
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        aborted_next   = aborted_reg;
        cmp_valid_next = cmp_valid_reg;
        rv_next        = rv_reg;
        code_next      = code_reg;
        is_char_next   = is_char_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        sp_next        = sp_reg;
        f_next         = f_reg;
        col_next       = col_reg;
        total_next     = total_reg;
        q_pop          = 1'b0;
        row_we         = 1'b0;
        sym_we         = 1'b0;
        shift_in       = 1'b0;
        shift_out      = 1'b0;
        out_push       = 1'b0;
        out_item.column_pattern = '0;
        out_item.status         = ttcpg_pkg::ST_OK;
        out_item.last           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        ttcpg_pkg::K_ROW:
                        begin
                            row_we = 1'b1;
                        end
                        ttcpg_pkg::K_SYMBOL:
                        begin
                            sym_we = 1'b1;
                        end
                        ttcpg_pkg::K_CHAR:
                        begin
                            count_next   = cnt_start;
                            aborted_next = abort_start;
                            code_next    = q_head.char_code;
                            col_next     = '0;
                            if (!abort_start)
                            begin
                                if (q_head.char_code == ttcpg_pkg::SPACE_CODE)
                                begin
                                    is_char_next = 1'b0;
                                    total_next   = TOT_W'(SPACING);
                                    if (SPACING > 0)
                                    begin
                                        state_next = S_EMIT;
                                    end
                                end
                                else
                                begin
                                    is_char_next   = 1'b1;
                                    total_next     = q_head.last_char ? TOT_W'(WIDTH)
                                                                      : TOT_W'(WIDTH + SPACING);
                                    idx_next       = '0;
                                    cmp_valid_next = 1'b0;
                                    state_next     = S_SEARCH;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (cmp_valid_reg && (sym_rdata == code_reg))
                begin
                    sp_next    = cmp_idx_reg;
                    f_next     = '0;
                    rv_next    = 1'b0;
                    state_next = S_FETCH;
                end
                else if (idx_reg < lim)
                begin
                    idx_next       = LIM_W'(idx_reg + 1'b1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[SIDX_W-1:0];
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else if (!out_full)
                begin
                    out_push        = 1'b1;
                    out_item.status = ttcpg_pkg::ST_UNKNOWN;
                    out_item.last   = 1'b1;
                    aborted_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_FETCH:
            begin
                if (f_reg < F_W'(HEIGHT))
                begin
                    f_next  = F_W'(f_reg + 1'b1);
                    rv_next = 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                end
                if (rv_reg)
                begin
                    shift_in = 1'b1;
                    if (f_reg == F_W'(HEIGHT))
                    begin
                        state_next = S_EMIT;
                    end
                end
            end

            S_EMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (count_reg >= max_columns)
                    begin
                        out_item.status = ttcpg_pkg::ST_OVERFLOW;
                        out_item.last   = 1'b1;
                        aborted_next    = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        if (is_char_reg && (col_reg < TOT_W'(WIDTH)))
                        begin
                            out_item.column_pattern = column_word;
                        end
                        out_item.last = col_last;
                        count_next    = MC_W'(count_reg + 1'b1);
                        col_next      = TOT_W'(col_reg + 1'b1);
                        shift_out     = 1'b1;
                        if (col_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            aborted_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            aborted_reg   <= aborted_next;
            cmp_valid_reg <= cmp_valid_next;
            rv_reg        <= rv_next;
        end
    end

    // Hold per-character working values
    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        is_char_reg <= is_char_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        sp_reg      <= sp_next;
        f_reg       <= f_next;
        col_reg     <= col_next;
        total_reg   <= total_next;
    end

    // Shift fetched rows in, then shift each row right once per column
    always_ff @(posedge clk)
    begin
        if (shift_in)
        begin
            for (int r = 0; r < HEIGHT - 1; r++)
            begin
                rowbuf_reg[r] <= rowbuf_reg[r + 1];
            end
            rowbuf_reg[HEIGHT - 1] <= row_rdata;
        end
        else if (shift_out)
        begin
            for (int r = 0; r < HEIGHT; r++)
            begin
                rowbuf_reg[r] <= rowbuf_reg[r] >> 1;
            end
        end
    end

    ttcpg_ram #(
        .DATA_W (RB_W),
        .DEPTH  (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (q_head.row_bits),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    ttcpg_ram #(
        .DATA_W (ttcpg_pkg::CODE_W),
        .DEPTH  (SYM_DEPTH)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (q_head.char_code),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

endmodule

// ----- design/text_to_column_pattern_generator_top.sv -----
// Column raster character generator.
// Input channel (push/full): load items write sprite rows and symbols into the
// font; text character items look up a sprite and produce column words. An
// item is taken when push is high and full is low.
// Result channel (empty/pop): the oldest result sits on column_pattern, status
// and last while empty is low; pop takes it. last marks the final result of
// an item. status reports column limit overflow and unknown symbols.
// Configuration: cfg_write with cfg_index 0 sets max_columns, 1 sets
// sprite_count; write only while the block is idle.
// The back end takes a load item from the input queue and writes it into the
// font. A character is taken from the queue, then passes through symbol
// search (one symbol RAM read per cycle), row fetch (one row RAM read per
// cycle) and column output, WIDTH + SPACING columns, or WIDTH when last_char
// is set. An unknown symbol ends the search with a status result. A space
// outputs SPACING blank columns. A four-entry input queue lets items arrive
// while a character is in work. When the receiver stalls, results back up in
// a two-entry output queue, the back end holds and the input queue fills
// until full rises. Reset empties both queues, clears the column count and
// the abort flag, sets max_columns to 65535 and sprite_count to 0. The font
// is not cleared and holds unknown values until loaded.
module text_to_column_pattern_generator_top #(
    parameter int WIDTH       = 36,
    parameter int HEIGHT      = 64,
    parameter int MAX_SPRITES = 64,
    parameter int SPACING     = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           opcode,
    input  logic [ttcpg_pkg::INDEX_W-1:0]        sprite_index,
    input  logic [ttcpg_pkg::INDEX_W-1:0]        row_index,
    input  logic [ttcpg_pkg::ROW_BITS_W-1:0]     row_bits,
    input  logic [ttcpg_pkg::CODE_W-1:0]         char_code,
    input  logic                                 first_char,
    input  logic                                 last_char,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ttcpg_pkg::PATTERN_W-1:0]      column_pattern,
    output logic [1:0]                           status,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [ttcpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [ttcpg_pkg::MAXCOL_W-1:0] max_columns_reg;
    logic [ttcpg_pkg::SCOUNT_W-1:0] sprite_count_reg;

    logic               q_pop;
    logic               q_empty;
    ttcpg_pkg::entry_t  q_head;
    logic               out_full;
    logic               out_push;
    ttcpg_pkg::result_t out_item;
    ttcpg_pkg::result_t out_head;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_columns_reg  <= '1;
            sprite_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ttcpg_pkg::CFG_MAX_COLUMNS)
            begin
                max_columns_reg <= cfg_data[ttcpg_pkg::MAXCOL_W-1:0];
            end
            else
            begin
                sprite_count_reg <= cfg_data[ttcpg_pkg::SCOUNT_W-1:0];
            end
        end
    end

    ttcpg_front #(
        .HEIGHT      (HEIGHT),
        .MAX_SPRITES (MAX_SPRITES),
        .QUEUE_DEPTH (4)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .sprite_index (sprite_index),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .char_code    (char_code),
        .first_char   (first_char),
        .last_char    (last_char),
        .q_pop        (q_pop),
        .q_empty      (q_empty),
        .q_head       (q_head)
    );

    ttcpg_back #(
        .WIDTH       (WIDTH),
        .HEIGHT      (HEIGHT),
        .MAX_SPRITES (MAX_SPRITES),
        .SPACING     (SPACING)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_columns  (max_columns_reg),
        .sprite_count (sprite_count_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_full     (out_full),
        .out_push     (out_push),
        .out_item     (out_item)
    );

    // Buffer results toward the receiver
    ttcpg_fifo #(
        .DATA_W ($bits(ttcpg_pkg::result_t)),
        .DEPTH  (2)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_head),
        .empty (empty)
    );

    assign column_pattern = out_head.column_pattern;
    assign status         = out_head.status;
    assign last           = out_head.last;

endmodule

// ----- design/ttcpg_checker.sv -----
module ttcpg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic [ttcpg_pkg::PATTERN_W-1:0]   column_pattern,
    input logic [1:0]                        status,
    input logic                              last
);

    // No result may be offered while reset holds
    a_empty_in_reset: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result offered during reset");

    // Status codes stay within the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ttcpg_pkg::ST_OK || status == ttcpg_pkg::ST_OVERFLOW ||
                    status == ttcpg_pkg::ST_UNKNOWN))
        else $error("undefined status code");

    // A status result ends its item and carries no column bits
    a_status_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ttcpg_pkg::ST_OK) |-> (last && column_pattern == '0))
        else $error("status result not final or carries column bits");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(column_pattern) && $stable(status) &&
                             $stable(last)))
        else $error("stalled result changed");

endmodule

bind text_to_column_pattern_generator_top ttcpg_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .column_pattern (column_pattern),
    .status         (status),
    .last           (last)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int WIDTH         = 36;
    localparam int HEIGHT        = 64;
    localparam int MAX_SPRITES   = 64;
    localparam int SPACING       = 4;
    localparam int GLYPHS        = 8;
    localparam int LOADED        = 3;
    localparam int PHASE_ITEMS   = 10;
    localparam int SETTLE_CYCLES = 1000;
    localparam int IDLE_LIMIT    = 20000;

    typedef struct {
        logic [1:0]                       op;
        logic [ttcpg_pkg::INDEX_W-1:0]    sidx;
        logic [ttcpg_pkg::INDEX_W-1:0]    ridx;
        logic [ttcpg_pkg::ROW_BITS_W-1:0] bits;
        logic [ttcpg_pkg::CODE_W-1:0]     code;
        logic                             first;
        logic                             fin;
    } font_item_t;

    // Font and text state mirror; predicts the column words of each transfer
    class column_scoreboard;
        bit [ttcpg_pkg::ROW_BITS_W-1:0] font_rows [MAX_SPRITES][HEIGHT];
        bit [ttcpg_pkg::CODE_W-1:0]     font_symbols [MAX_SPRITES];
        bit [ttcpg_pkg::MAXCOL_W-1:0]   max_columns;
        bit [ttcpg_pkg::SCOUNT_W-1:0]   sprite_count;
        bit [ttcpg_pkg::MAXCOL_W-1:0]   column_count;
        bit                             text_aborted;
        ttcpg_pkg::result_t             pending_columns [$];
        int                             errors;
        int                             columns_seen;
        int                             overflows;
        int                             unknowns;

        function new();
            max_columns  = '1;
            sprite_count = '0;
            column_count = '0;
            text_aborted = 1'b0;
        endfunction

        function void write_register(logic idx, logic [ttcpg_pkg::CFG_DATA_W-1:0] data);
            if (idx == ttcpg_pkg::CFG_MAX_COLUMNS)
                max_columns = data;
            else
                sprite_count = data[ttcpg_pkg::SCOUNT_W-1:0];
        endfunction

        function void push_status(ttcpg_pkg::status_t st);
            ttcpg_pkg::result_t r;
            r.column_pattern = '0;
            r.status         = st;
            r.last           = 1'b0;
            pending_columns.push_back(r);
            text_aborted = 1'b1;
        endfunction

        // Queue one column, or an overflow once the limit is reached
        function bit emit_column(logic [ttcpg_pkg::PATTERN_W-1:0] pattern);
            ttcpg_pkg::result_t r;
            if (column_count >= max_columns) begin
                push_status(ttcpg_pkg::ST_OVERFLOW);
                return 1'b0;
            end
            r.column_pattern = pattern;
            r.status         = ttcpg_pkg::ST_OK;
            r.last           = 1'b0;
            pending_columns.push_back(r);
            column_count++;
            return 1'b1;
        endfunction

        function bit emit_gap();
            for (int s = 0; s < SPACING; s++)
                if (!emit_column('0))
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_item(font_item_t it);
            int                              base;
            int                              hit;
            int                              lim;
            bit                              ok;
            logic [ttcpg_pkg::PATTERN_W-1:0] col;
            base = pending_columns.size();
            case (it.op)
                ttcpg_pkg::OP_LOAD_ROW:    font_rows[it.sidx][it.ridx] = it.bits;
                ttcpg_pkg::OP_LOAD_SYMBOL: font_symbols[it.sidx] = it.code;
                ttcpg_pkg::OP_TEXT_CHAR:
                begin
                    if (it.first) begin
                        column_count = '0;
                        text_aborted = 1'b0;
                    end
                    if (!text_aborted) begin
                        if (it.code == ttcpg_pkg::SPACE_CODE) begin
                            void'(emit_gap());
                        end
                        else begin
                            // first sprite in the searched range that carries the symbol
                            hit = -1;
                            lim = (int'(sprite_count) > MAX_SPRITES) ? MAX_SPRITES
                                                                     : int'(sprite_count);
                            for (int i = 0; i < lim && hit < 0; i++)
                                if (font_symbols[i] == it.code)
                                    hit = i;
                            if (hit < 0) begin
                                push_status(ttcpg_pkg::ST_UNKNOWN);
                            end
                            else begin
                                ok = 1'b1;
                                // transpose: bit r of column x is bit x of row r
                                for (int x = 0; x < WIDTH && ok; x++) begin
                                    col = '0;
                                    for (int r = 0; r < HEIGHT; r++)
                                        col[r] = font_rows[hit][r][x];
                                    ok = emit_column(col);
                                end
                                if (ok && !it.fin)
                                    void'(emit_gap());
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (pending_columns.size() > base)
                pending_columns[pending_columns.size() - 1].last = 1'b1;
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_column(logic [ttcpg_pkg::PATTERN_W-1:0] pattern, logic [1:0] st,
                          logic lst);
            ttcpg_pkg::result_t want;
            if (pending_columns.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h status %0d last %0b",
                                        pattern, st, lst));
                return;
            end
            want = pending_columns.pop_front();
            columns_seen++;
            if (want.status == ttcpg_pkg::ST_OVERFLOW)
                overflows++;
            if (want.status == ttcpg_pkg::ST_UNKNOWN)
                unknowns++;
            if (pattern !== want.column_pattern)
                flag_mismatch($sformatf("column %0d pattern %h, want %h",
                                        columns_seen, pattern, want.column_pattern));
            if (st !== want.status)
                flag_mismatch($sformatf("column %0d status %0d, want %0d",
                                        columns_seen, st, want.status));
            if (lst !== want.last)
                flag_mismatch($sformatf("column %0d last %0b, want %0b",
                                        columns_seen, lst, want.last));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             push = 1'b0;
    logic                             full;
    logic [1:0]                       opcode = '0;
    logic [ttcpg_pkg::INDEX_W-1:0]    sprite_index = '0;
    logic [ttcpg_pkg::INDEX_W-1:0]    row_index = '0;
    logic [ttcpg_pkg::ROW_BITS_W-1:0] row_bits = '0;
    logic [ttcpg_pkg::CODE_W-1:0]     char_code = '0;
    logic                             first_char = 1'b0;
    logic                             last_char = 1'b0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [ttcpg_pkg::PATTERN_W-1:0]  column_pattern;
    logic [1:0]                       status;
    logic                             last;
    logic                             cfg_write = 1'b0;
    logic                             cfg_index = 1'b0;
    logic [ttcpg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    column_scoreboard   board;
    bit [HEIGHT-1:0]    rows_seen [MAX_SPRITES];
    bit                 steady = 1'b0;
    int                 pop_hold = 0;
    int                 quiet_cycles = 0;
    int                 items_sent = 0;
    int                 chars_sent = 0;
    int                 settings_used = 0;

    text_to_column_pattern_generator_top #(
        .WIDTH       (WIDTH),
        .HEIGHT      (HEIGHT),
        .MAX_SPRITES (MAX_SPRITES),
        .SPACING     (SPACING)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .sprite_index   (sprite_index),
        .row_index      (row_index),
        .row_bits       (row_bits),
        .char_code      (char_code),
        .first_char     (first_char),
        .last_char      (last_char),
        .empty          (empty),
        .pop            (pop),
        .column_pattern (column_pattern),
        .status         (status),
        .last           (last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Toggle stretches with no idling on either side
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            steady <= !steady;
    end

    // Receiver: take results with random stalls
    always @(posedge clk)
    begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else begin
            pop      <= 1'b1;
            pop_hold <= draw_gap();
        end
    end

    // Observe transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            board.note_item('{opcode, sprite_index, row_index, row_bits,
                              char_code, first_char, last_char});
        if (rst_n && pop && !empty)
            board.check_column(column_pattern, status, last);
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic font_item_t random_item(logic [1:0] op);
        font_item_t  it;
        logic [63:0] rnd;
        rnd      = {$urandom, $urandom};
        it.op    = op;
        it.bits  = rnd[ttcpg_pkg::ROW_BITS_W-1:0];
        rnd      = {$urandom, $urandom};
        it.sidx  = rnd[ttcpg_pkg::INDEX_W-1:0];
        it.ridx  = rnd[ttcpg_pkg::INDEX_W+7:8];
        it.code  = rnd[ttcpg_pkg::CODE_W+15:16];
        it.first = rnd[32];
        it.fin   = rnd[33];
        return it;
    endfunction

    function automatic font_item_t text_char(logic [ttcpg_pkg::CODE_W-1:0] code, logic first,
                                             logic fin);
        font_item_t it;
        it       = random_item(ttcpg_pkg::OP_TEXT_CHAR);
        it.code  = code;
        it.first = first;
        it.fin   = fin;
        return it;
    endfunction

    // A symbol write is allowed only if every symbol still resolves to a fully loaded sprite
    function automatic bit font_safe(int sidx, logic [ttcpg_pkg::CODE_W-1:0] code);
        bit [ttcpg_pkg::CODE_W-1:0] sym [MAX_SPRITES];
        int                         j;
        sym       = board.font_symbols;
        sym[sidx] = code;
        for (int i = 0; i < MAX_SPRITES; i++) begin
            if (sym[i] != ttcpg_pkg::SPACE_CODE) begin
                j = 0;
                while (sym[j] != sym[i])
                    j++;
                if (rows_seen[j] != '1)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(font_item_t it);
        push         <= 1'b1;
        opcode       <= it.op;
        sprite_index <= it.sidx;
        row_index    <= it.ridx;
        row_bits     <= it.bits;
        char_code    <= it.code;
        first_char   <= it.first;
        last_char    <= it.fin;
        do
            @(posedge clk);
        while (full);
        if (it.op == ttcpg_pkg::OP_LOAD_ROW)
            rows_seen[it.sidx][it.ridx] = 1'b1;
        if (it.op == ttcpg_pkg::OP_TEXT_CHAR)
            chars_sent++;
        items_sent++;
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drain the block, then write both registers back to back
    task automatic change_settings(logic [ttcpg_pkg::CFG_DATA_W-1:0] maxcol,
                                   logic [ttcpg_pkg::CFG_DATA_W-1:0] scount);
        push <= 1'b0;
        @(posedge clk);
        while (board.pending_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= ttcpg_pkg::CFG_MAX_COLUMNS;
        cfg_data  <= maxcol;
        @(posedge clk);
        board.write_register(ttcpg_pkg::CFG_MAX_COLUMNS, maxcol);
        cfg_index <= ttcpg_pkg::CFG_SPRITE_COUNT;
        cfg_data  <= scount;
        @(posedge clk);
        board.write_register(ttcpg_pkg::CFG_SPRITE_COUNT, scount);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [ttcpg_pkg::CODE_W-1:0]     glyphs [GLYPHS];
        logic [ttcpg_pkg::CFG_DATA_W-1:0] phase_max [7];
        logic [ttcpg_pkg::CFG_DATA_W-1:0] phase_count [7];
        font_item_t                       it;
        logic [ttcpg_pkg::CODE_W-1:0]     code;
        logic [31:0]                      rnd;
        int                               sent;
        int                               len;
        int                               roll;
        logic                             first;
        logic                             fin;

        rst_n <= 1'b0;
        glyphs      = '{8'h00, 8'hFF, 8'h41, 8'h7E, 8'h80, 8'h21, 8'h5A, 8'h30};
        phase_max   = '{16'hFFFF, 16'd100, 16'd37, 16'd1, 16'd300, 16'd0, 16'd2000};
        phase_count = '{16'd8, 16'd64, 16'd5, 16'd1, 16'hFFFF, 16'd8, 16'd64};
        board = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Load full bitmaps for the first sprites: all ones, all zeros, then random
        for (int s = 0; s < LOADED; s++) begin
            for (int r = 0; r < HEIGHT; r++) begin
                it      = random_item(ttcpg_pkg::OP_LOAD_ROW);
                it.sidx = s[ttcpg_pkg::INDEX_W-1:0];
                it.ridx = r[ttcpg_pkg::INDEX_W-1:0];
                if (s == 0)
                    it.bits = '1;
                else if (s == 1)
                    it.bits = '0;
                send_item(it);
                hold_off(draw_gap());
            end
        end
        // Every symbol is written; the rest repeat the first glyph so lookups stay loaded
        for (int s = 0; s < MAX_SPRITES; s++) begin
            it      = random_item(ttcpg_pkg::OP_LOAD_SYMBOL);
            it.sidx = s[ttcpg_pkg::INDEX_W-1:0];
            it.code = (s < LOADED) ? glyphs[s] : glyphs[0];
            send_item(it);
            hold_off(draw_gap());
        end

        // Reset settings: nothing is searched, so any symbol is unknown
        send_item(text_char(glyphs[0], 1'b1, 1'b1));
        send_item(text_char(glyphs[0], 1'b0, 1'b0));
        send_item(text_char(ttcpg_pkg::SPACE_CODE, 1'b1, 1'b0));
        send_item(random_item(ttcpg_pkg::OP_UNUSED));

        // Full limit: columns, gaps, continuing after last, unknown, abort
        change_settings(16'hFFFF, 16'd8);
        send_item(text_char(glyphs[0], 1'b1, 1'b0));
        send_item(text_char(glyphs[1], 1'b0, 1'b1));
        send_item(text_char(glyphs[2], 1'b0, 1'b1));
        send_item(text_char(ttcpg_pkg::SPACE_CODE, 1'b0, 1'b0));
        send_item(text_char(8'h55, 1'b0, 1'b0));
        send_item(text_char(glyphs[3], 1'b0, 1'b0));
        send_item(text_char(glyphs[3], 1'b1, 1'b1));
        it      = random_item(ttcpg_pkg::OP_LOAD_SYMBOL);
        it.sidx = 6'd2;
        it.code = glyphs[5];
        send_item(it);
        send_item(text_char(glyphs[5], 1'b1, 1'b1));
        send_item(text_char(glyphs[2], 1'b1, 1'b0));

        // Limit of one column
        change_settings(16'd1, 16'd64);
        send_item(text_char(glyphs[1], 1'b1, 1'b0));
        send_item(text_char(ttcpg_pkg::SPACE_CODE, 1'b1, 1'b0));

        // Limit of zero, oversized sprite count
        change_settings(16'd0, 16'hFFFF);
        send_item(text_char(glyphs[0], 1'b1, 1'b1));

        // Limit that fits exactly one character plus its gap
        change_settings(16'd40, 16'd3);
        send_item(text_char(glyphs[0], 1'b1, 1'b0));
        send_item(text_char(glyphs[1], 1'b0, 1'b0));
        send_item(text_char(glyphs[2], 1'b0, 1'b1));
        send_item(text_char(glyphs[4], 1'b1, 1'b0));
        send_item(text_char(ttcpg_pkg::SPACE_CODE, 1'b1, 1'b1));

        // Random phases: mostly well formed texts, some font updates and noise
        for (int p = 0; p < 7; p++) begin
            change_settings(phase_max[p], phase_count[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        roll = $urandom_range(0, 99);
                        rnd  = $urandom;
                        if (roll < 50)
                            code = board.font_symbols[$urandom_range(0, LOADED - 1)];
                        else if (roll < 75)
                            code = ttcpg_pkg::SPACE_CODE;
                        else
                            code = rnd[ttcpg_pkg::CODE_W-1:0];
                        first = (k == 0);
                        fin   = (k == len - 1);
                        if ($urandom_range(0, 9) == 0)
                            first = rnd[8];
                        if ($urandom_range(0, 9) == 0)
                            fin = rnd[9];
                        send_item(text_char(code, first, fin));
                        hold_off(draw_gap());
                        sent++;
                    end
                end
                else if (roll < 88) begin
                    send_item(random_item(ttcpg_pkg::OP_LOAD_ROW));
                    hold_off(draw_gap());
                    sent++;
                end
                else if (roll < 97) begin
                    it = random_item(ttcpg_pkg::OP_LOAD_SYMBOL);
                    if ($urandom_range(0, 1) == 0)
                        it.code = glyphs[$urandom_range(0, GLYPHS - 1)];
                    if (font_safe(int'(it.sidx), it.code)) begin
                        send_item(it);
                        hold_off(draw_gap());
                        sent++;
                    end
                end
                else begin
                    send_item(random_item(ttcpg_pkg::OP_UNUSED));
                    hold_off(draw_gap());
                end
            end
        end

        // Drain and allow stray results to show up
        push <= 1'b0;
        @(posedge clk);
        while (board.pending_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items, %0d of them text characters, under %0d register settings",
                 items_sent, chars_sent, settings_used);
        $display("Checked %0d result words: %0d column limit overflows, %0d unknown symbols",
                 board.columns_seen, board.overflows, board.unknowns);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ttcpg_pkg.sv
design/ttcpg_ram.sv
design/ttcpg_fifo.sv
design/ttcpg_front.sv
design/ttcpg_back.sv
design/text_to_column_pattern_generator_top.sv
design/ttcpg_checker.sv
tb/sv/testbench.sv
